@@ hw/rtl/tbep_pkg.sv @@
`default_nettype none

package tbep_pkg;

  // tag bytes that open an element, and the zero-string terminator
  localparam logic [7:0] TAG_ZSTRING = 8'h01;
  localparam logic [7:0] TAG_CSTRING = 8'h02;
  localparam logic [7:0] TAG_INTEGER = 8'h03;
  localparam logic [7:0] TERMINATOR  = 8'h00;

  // integer mode bytes
  localparam logic [7:0] MODE_INT8  = 8'h01;
  localparam logic [7:0] MODE_INT16 = 8'h02;
  localparam logic [7:0] MODE_INT32 = 8'h03;

  // element kinds on the result channel
  typedef enum logic [1:0] {
    KIND_STRING = 2'd0,
    KIND_INT8   = 2'd1,
    KIND_INT16  = 2'd2,
    KIND_INT32  = 2'd3
  } elem_kind_t;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_ZSTR    = 6'b000010,
    PH_LEN     = 6'b000100,
    PH_CBODY   = 6'b001000,
    PH_MODE    = 6'b010000,
    PH_INTBYTE = 6'b100000
  } phase_t;

  // one result transaction
  typedef struct packed {
    elem_kind_t  kind;
    logic [31:0] value;
    logic        has_value;
    logic        elem_end;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/tbep_parser.sv @@
`default_nettype none

module tbep_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  output logic               res_valid,
  output tbep_pkg::res_t     res
);
  import tbep_pkg::*;

  localparam logic [1:0] LEN_LAST_IDX = 2'd3;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic [31:0] asm_r, asm_nxt;
  elem_kind_t  mode_r, mode_nxt;

  logic [31:0] shifted;
  logic [31:0] remain_dec;
  logic [1:0]  int_last;

  assign shifted    = {asm_r[23:0], data_byte};
  assign remain_dec = remain_r - 32'd1;

  always_comb begin
    case (mode_r)
      KIND_INT8:  int_last = 2'd0;
      KIND_INT16: int_last = 2'd1;
      KIND_INT32: int_last = 2'd3;
      default:    int_last = 2'd0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    remain_nxt = remain_r;
    asm_nxt    = asm_r;
    mode_nxt   = mode_r;
    res_valid  = 1'b0;
    res        = '{kind: KIND_STRING, value: 32'd0, has_value: 1'b0, elem_end: 1'b0};
    if (accept) begin
      case (phase_r)
        PH_ZSTR: begin
          res_valid = 1'b1;
          if (data_byte == TERMINATOR) begin
            phase_nxt    = PH_IDLE;
            res.elem_end = 1'b1;
          end else begin
            res.value     = {24'd0, data_byte};
            res.has_value = 1'b1;
          end
        end
        PH_LEN: begin
          asm_nxt = shifted;
          if (cnt_r == LEN_LAST_IDX) begin
            cnt_nxt    = 2'd0;
            remain_nxt = shifted;
            if (shifted == 32'd0) begin
              phase_nxt    = PH_IDLE;
              res_valid    = 1'b1;
              res.elem_end = 1'b1;
            end else begin
              phase_nxt = PH_CBODY;
            end
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        PH_CBODY: begin
          remain_nxt    = remain_dec;
          res_valid     = 1'b1;
          res.value     = {24'd0, data_byte};
          res.has_value = 1'b1;
          if (remain_dec == 32'd0) begin
            phase_nxt    = PH_IDLE;
            res.elem_end = 1'b1;
          end
        end
        PH_MODE: begin
          if (data_byte inside {MODE_INT8, MODE_INT16, MODE_INT32}) begin
            mode_nxt  = elem_kind_t'(data_byte[1:0]);
            cnt_nxt   = 2'd0;
            asm_nxt   = 32'd0;
            phase_nxt = PH_INTBYTE;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_INTBYTE: begin
          asm_nxt = shifted;
          if (cnt_r == int_last) begin
            phase_nxt     = PH_IDLE;
            cnt_nxt       = 2'd0;
            res_valid     = 1'b1;
            res.kind      = mode_r;
            res.value     = shifted;
            res.has_value = 1'b1;
            res.elem_end  = 1'b1;
          end else begin
            cnt_nxt = cnt_r + 2'd1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          case (data_byte)
            TAG_ZSTRING: phase_nxt = PH_ZSTR;
            TAG_CSTRING: begin
              phase_nxt = PH_LEN;
              cnt_nxt   = 2'd0;
              asm_nxt   = 32'd0;
            end
            TAG_INTEGER: phase_nxt = PH_MODE;
            default:     phase_nxt = PH_IDLE;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cnt_r    <= 2'd0;
      remain_r <= 32'd0;
      asm_r    <= 32'd0;
      mode_r   <= KIND_STRING;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      asm_r    <= asm_nxt;
      mode_r   <= mode_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tbep_out_buf.sv @@
`default_nettype none

module tbep_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tbep_pkg::res_t push_data,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tbep_pkg::res_t      out_data
);
  import tbep_pkg::*;

  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  assign take      = main_vld_r & ~out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // no push possible while the skid entry is occupied
      if (take) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_vld_r || take) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      main_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/tagged_binary_element_parser_top.sv @@
`default_nettype none

// channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------------
// in_     | input     | in_valid / in_stall   | in_data_byte[7:0]
// out_    | output    | out_valid / out_stall | out_elem_kind/_value/_end, out_has_value
//
// one byte per cycle while in_stall is low, as set by the parser state update; a byte's
// result (if any) shows on out_ the cycle after it is taken unless an older one is held
// synchronous active-low reset returns the parser to idle and empties the output buffer
// a two-entry output buffer separates the sides; in_stall is a registered full flag
// so the input keeps flowing for one extra result while out_stall is held

module tagged_binary_element_parser_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  // element results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_elem_kind,
  output logic [31:0]      out_elem_value,
  output logic             out_has_value,
  output logic             out_elem_end
);
  import tbep_pkg::*;

  logic in_accept;
  logic res_valid;
  res_t res;
  res_t out_data;
  logic buf_full;

  // a byte is taken whenever the skid entry is free
  assign in_stall  = buf_full;
  assign in_accept = in_valid & ~buf_full;

  // state machine: tag, length, mode and body tracking
  tbep_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register plus skid entry
  tbep_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_elem_kind  = out_data.kind;
  assign out_elem_value = out_data.value;
  assign out_has_value  = out_data.has_value;
  assign out_elem_end   = out_data.elem_end;

endmodule

`default_nettype wire
